### sv/ffha_pkg.sv
`default_nettype none
package ffha_pkg;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_OOM      = 2'd1;
  localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

  localparam int REQ_W = 16;
  localparam int PU_W  = 12;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_A_DIV,
    S_A_LOOP,
    S_A_WAIT,
    S_A_TAKE,
    S_A_APPEND,
    S_A_NEW,
    S_OOM,
    S_F_CHECK,
    S_F_LOOP,
    S_F_WAIT,
    S_F_HIT,
    S_F_DO,
    S_BAD,
    S_OUT
  } step_t;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_IN_VALID,
    C_OP_FREE,
    C_H_END,
    C_NOFIT,
    C_NOROOM,
    C_PU_ZERO,
    C_F_STOP,
    C_F_MISS,
    C_BLK_FREE,
    C_OUT_BUSY
  } cond_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_TAKE,
    ACT_NEW,
    ACT_OOM,
    ACT_FREE,
    ACT_BAD
  } act_t;

  typedef struct packed {
    logic  accept;
    logic  div_q;
    logic  div_fix;
    logic  mem_rd;
    logic  adv;
    act_t  act;
    logic  out_stage;
    cond_t cond;
    step_t jmp;
    step_t nxt;
  } ucw_t;

  typedef struct packed {
    ucw_t uw;
    logic taken;
  } ctl_t;

  typedef struct packed {
    logic in_valid;
    logic op_free;
    logic h_end;
    logic nofit;
    logic noroom;
    logic pu_zero;
    logic f_stop;
    logic f_miss;
    logic blk_free;
    logic out_busy;
  } flags_t;

  function automatic ucw_t ucode(step_t s);
    ucw_t w;
    w = '0;
    case (s)
      S_IDLE: begin
        w.accept = 1'b1;
        w.cond   = C_IN_VALID;
        w.jmp    = S_DISPATCH;
        w.nxt    = S_IDLE;
      end
      S_DISPATCH: begin
        w.div_q = 1'b1;
        w.cond  = C_OP_FREE;
        w.jmp   = S_F_CHECK;
        w.nxt   = S_A_DIV;
      end
      S_A_DIV: begin
        w.div_fix = 1'b1;
        w.cond    = C_ALWAYS;
        w.jmp     = S_A_LOOP;
      end
      S_A_LOOP: begin
        w.mem_rd = 1'b1;
        w.cond   = C_H_END;
        w.jmp    = S_A_APPEND;
        w.nxt    = S_A_WAIT;
      end
      S_A_WAIT: begin
        w.adv  = 1'b1;
        w.cond = C_NOFIT;
        w.jmp  = S_A_LOOP;
        w.nxt  = S_A_TAKE;
      end
      S_A_TAKE: begin
        w.act  = ACT_TAKE;
        w.cond = C_ALWAYS;
        w.jmp  = S_OUT;
      end
      S_A_APPEND: begin
        w.cond = C_NOROOM;
        w.jmp  = S_OOM;
        w.nxt  = S_A_NEW;
      end
      S_A_NEW: begin
        w.act  = ACT_NEW;
        w.cond = C_ALWAYS;
        w.jmp  = S_OUT;
      end
      S_OOM: begin
        w.act  = ACT_OOM;
        w.cond = C_ALWAYS;
        w.jmp  = S_OUT;
      end
      S_F_CHECK: begin
        w.cond = C_PU_ZERO;
        w.jmp  = S_BAD;
        w.nxt  = S_F_LOOP;
      end
      S_F_LOOP: begin
        w.mem_rd = 1'b1;
        w.cond   = C_F_STOP;
        w.jmp    = S_BAD;
        w.nxt    = S_F_WAIT;
      end
      S_F_WAIT: begin
        w.adv  = 1'b1;
        w.cond = C_F_MISS;
        w.jmp  = S_F_LOOP;
        w.nxt  = S_F_HIT;
      end
      S_F_HIT: begin
        w.cond = C_BLK_FREE;
        w.jmp  = S_BAD;
        w.nxt  = S_F_DO;
      end
      S_F_DO: begin
        w.act  = ACT_FREE;
        w.cond = C_ALWAYS;
        w.jmp  = S_OUT;
      end
      S_BAD: begin
        w.act  = ACT_BAD;
        w.cond = C_ALWAYS;
        w.jmp  = S_OUT;
      end
      S_OUT: begin
        w.out_stage = 1'b1;
        w.cond      = C_OUT_BUSY;
        w.jmp       = S_OUT;
        w.nxt       = S_IDLE;
      end
      default: begin
        w.cond = C_ALWAYS;
        w.jmp  = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

### sv/ffha_if.sv
`default_nettype none
interface ffha_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] request_bytes;
  logic [11:0] payload_unit;

  modport source (output valid, output operation, output request_bytes,
                  output payload_unit, input ready);
  modport sink (input valid, input operation, input request_bytes,
                input payload_unit, output ready);
endinterface

interface ffha_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [11:0] block_unit;
  logic        reused;
  logic [15:0] bytes_in_use;

  modport source (output valid, output status, output block_unit,
                  output reused, output bytes_in_use, input ready);
  modport sink (input valid, input status, input block_unit,
                input reused, input bytes_in_use, output ready);
endinterface
`default_nettype wire

### sv/ffha_sequencer.sv
`default_nettype none
module ffha_sequencer (
  input  logic            clk,
  input  logic            rst_n,
  input  ffha_pkg::flags_t flags,
  output ffha_pkg::ctl_t   ctl
);
  import ffha_pkg::*;

  step_t step_r;
  step_t step_nxt;
  ucw_t  uw;
  logic  taken;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_comb begin
    uw = ucode(step_r);
    case (uw.cond)
      C_ALWAYS:   taken = 1'b1;
      C_IN_VALID: taken = flags.in_valid;
      C_OP_FREE:  taken = flags.op_free;
      C_H_END:    taken = flags.h_end;
      C_NOFIT:    taken = flags.nofit;
      C_NOROOM:   taken = flags.noroom;
      C_PU_ZERO:  taken = flags.pu_zero;
      C_F_STOP:   taken = flags.f_stop;
      C_F_MISS:   taken = flags.f_miss;
      C_BLK_FREE: taken = flags.blk_free;
      C_OUT_BUSY: taken = flags.out_busy;
      default:    taken = 1'b1;
    endcase
    step_nxt  = taken ? uw.jmp : uw.nxt;
    ctl.uw    = uw;
    ctl.taken = taken;
  end

  step_t prev_step_r;
  always_ff @(posedge clk) begin
    prev_step_r <= step_r;
  end

  a_out_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (uw.out_stage && !flags.out_busy) |=> (step_r == S_IDLE))
    else $error("result stage did not return to idle");

  a_accept_dispatches: assert property (@(posedge clk) disable iff (!rst_n)
    (uw.accept && flags.in_valid) |=> (step_r == S_DISPATCH))
    else $error("accepted word not dispatched");

  a_walk_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == S_A_WAIT) |-> (prev_step_r == S_A_LOOP))
    else $error("header check without a preceding read");

endmodule
`default_nettype wire

### sv/ffha_datapath.sv
`default_nettype none
module ffha_datapath #(
  parameter int HEAP_UNITS = 4096,
  parameter int UNIT_BYTES = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  ffha_req_if.sink         in_ch,
  ffha_rsp_if.source       out_ch,
  input  ffha_pkg::ctl_t   ctl,
  output ffha_pkg::flags_t flags
);
  import ffha_pkg::*;

  localparam int AW   = $clog2(HEAP_UNITS);
  localparam int HW   = AW + 1;
  localparam int MAXQ = (65535 + UNIT_BYTES - 1) / UNIT_BYTES;
  localparam int NW   = $clog2(MAXQ + 1);
  localparam int UBW  = $clog2(UNIT_BYTES + 1);
  localparam int CBW  = (AW + UBW > REQ_W) ? (AW + UBW) : REQ_W;
  localparam int XW   = (HW > PU_W) ? HW : PU_W;
  localparam int SW   = ((HW > NW) ? HW : NW) + 1;
  localparam int DW   = REQ_W + 1;
  localparam int RCP  = (1 << DW) / UNIT_BYTES;

  typedef struct packed {
    logic             in_use;
    logic [REQ_W-1:0] bytes;
    logic [AW-1:0]    cap;
  } hdr_t;

  hdr_t mem [HEAP_UNITS];
  hdr_t rd_r;

  logic             op_r;
  logic [REQ_W-1:0] req_r;
  logic [PU_W-1:0]  pu_r;
  logic [HW-1:0]    h_r;
  logic [HW-1:0]    end_r;
  logic [REQ_W-1:0] total_r;
  logic [NW-1:0]    q_r;
  logic [1:0]       res_status_r;
  logic [PU_W-1:0]  res_block_r;
  logic             res_reused_r;
  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [PU_W-1:0]  out_block_r;
  logic             out_reused_r;
  logic [REQ_W-1:0] out_bytes_r;

  logic             acc;
  logic             rd_en;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  hdr_t             wr_data;
  logic [DW-1:0]    div_x;
  logic [2*DW-1:0]  div_prod;
  logic [DW:0]      div_rem;
  logic [NW-1:0]    q_fix;
  logic [CBW-1:0]   cap_bytes;
  logic [HW-1:0]    h_next;
  logic [SW-1:0]    need_sum;
  logic [SW-1:0]    end_plus1;
  logic [XW-1:0]    tgt;
  logic [XW-1:0]    hx;
  logic [XW-1:0]    take_blk;
  logic [XW-1:0]    new_blk;
  logic [REQ_W:0]   sum_add;
  logic [REQ_W-1:0] total_add;
  logic [REQ_W-1:0] total_sub;
  logic             out_busy;

  assign acc          = ctl.uw.accept && rst_n && in_ch.valid;
  assign in_ch.ready  = ctl.uw.accept && rst_n;
  assign out_busy     = out_valid_r && !out_ch.ready;

  assign div_x    = DW'(req_r) + DW'(UNIT_BYTES - 1);
  assign div_prod = (2*DW)'(div_x) * (2*DW)'(RCP);
  assign div_rem  = (DW+1)'(div_x) - (DW+1)'(q_r) * (DW+1)'(UNIT_BYTES);
  assign q_fix    = (div_rem >= (DW+1)'(UNIT_BYTES)) ? q_r + 1'b1 : q_r;

  assign cap_bytes = CBW'(rd_r.cap) * CBW'(UNIT_BYTES);
  assign h_next    = h_r + HW'(1) + HW'(rd_r.cap);
  assign end_plus1 = SW'(end_r) + SW'(1);
  assign need_sum  = end_plus1 + SW'(q_r);
  assign tgt       = XW'(pu_r) - XW'(1);
  assign hx        = XW'(h_r);
  assign take_blk  = XW'(h_r) + XW'(1);
  assign new_blk   = XW'(end_r) + XW'(1);

  assign sum_add   = (REQ_W+1)'(total_r) + (REQ_W+1)'(req_r);
  assign total_add = sum_add[REQ_W] ? {REQ_W{1'b1}} : sum_add[REQ_W-1:0];
  assign total_sub = (total_r >= rd_r.bytes) ? total_r - rd_r.bytes : '0;

  always_comb begin
    flags.in_valid = in_ch.valid;
    flags.op_free  = op_r;
    flags.h_end    = (h_r >= end_r);
    flags.nofit    = rd_r.in_use || (cap_bytes < CBW'(req_r));
    flags.noroom   = (need_sum > SW'(HEAP_UNITS)) || (end_plus1 >= SW'(HEAP_UNITS));
    flags.pu_zero  = (pu_r == '0);
    flags.f_stop   = (h_r >= end_r) || (hx > tgt);
    flags.f_miss   = (hx != tgt);
    flags.blk_free = !rd_r.in_use;
    flags.out_busy = out_busy;
  end

  assign rd_en = ctl.uw.mem_rd && (h_r < end_r);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = h_r[AW-1:0];
    wr_data = rd_r;
    case (ctl.uw.act)
      ACT_TAKE: begin
        wr_en   = 1'b1;
        wr_data = '{in_use: 1'b1, bytes: req_r, cap: rd_r.cap};
      end
      ACT_NEW: begin
        wr_en   = 1'b1;
        wr_addr = end_r[AW-1:0];
        wr_data = '{in_use: 1'b1, bytes: req_r, cap: AW'(q_r)};
      end
      ACT_FREE: begin
        wr_en   = 1'b1;
        wr_data = '{in_use: 1'b0, bytes: '0, cap: rd_r.cap};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_r <= mem[h_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      op_r  <= in_ch.operation;
      req_r <= in_ch.request_bytes;
      pu_r  <= in_ch.payload_unit;
      h_r   <= '0;
    end else if (ctl.uw.adv && ctl.taken) begin
      h_r <= h_next;
    end
    if (ctl.uw.div_q) begin
      q_r <= NW'(div_prod[2*DW-1:DW]);
    end else if (ctl.uw.div_fix) begin
      q_r <= q_fix;
    end
    case (ctl.uw.act)
      ACT_TAKE: begin
        res_status_r <= STATUS_OK;
        res_block_r  <= take_blk[PU_W-1:0];
        res_reused_r <= 1'b1;
      end
      ACT_NEW: begin
        res_status_r <= STATUS_OK;
        res_block_r  <= new_blk[PU_W-1:0];
        res_reused_r <= 1'b0;
      end
      ACT_OOM: begin
        res_status_r <= STATUS_OOM;
        res_block_r  <= '0;
        res_reused_r <= 1'b0;
      end
      ACT_FREE: begin
        res_status_r <= STATUS_OK;
        res_block_r  <= pu_r;
        res_reused_r <= 1'b0;
      end
      ACT_BAD: begin
        res_status_r <= STATUS_BAD_FREE;
        res_block_r  <= '0;
        res_reused_r <= 1'b0;
      end
      default: begin
        res_status_r <= res_status_r;
      end
    endcase
    if (ctl.uw.out_stage && !out_busy) begin
      out_status_r <= res_status_r;
      out_block_r  <= res_block_r;
      out_reused_r <= res_reused_r;
      out_bytes_r  <= total_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (ctl.uw.act)
        ACT_TAKE: total_r <= total_add;
        ACT_NEW: begin
          total_r <= total_add;
          end_r   <= need_sum[HW-1:0];
        end
        ACT_FREE: total_r <= total_sub;
        default:  total_r <= total_r;
      endcase
      if (ctl.uw.out_stage && !out_busy) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.block_unit   = out_block_r;
  assign out_ch.reused       = out_reused_r;
  assign out_ch.bytes_in_use = out_bytes_r;

  a_take_free_only: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.uw.act == ACT_TAKE) |-> !rd_r.in_use)
    else $error("took a block that is in use");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.uw.act == ACT_NEW) |=> (end_r > $past(end_r)))
    else $error("append did not advance heap end");

  a_free_lowers_total: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.uw.act == ACT_FREE) |=> (total_r <= $past(total_r)))
    else $error("free raised byte total");

  a_heap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.uw.act == ACT_NEW) |=> (end_r <= HW'(HEAP_UNITS)))
    else $error("heap end passed heap size");

endmodule
`default_nettype wire

### sv/first_fit_heap_allocator_core.sv
`default_nettype none
// channel  dir  handshake    payload
// in_ch    in   valid/ready  operation, request_bytes, payload_unit
// out_ch   out  valid/ready  status, block_unit, reused, bytes_in_use
//
// Allocate: headers are walked from the heap start until a free one fits or the heap
// end; the single registered read port gives each header a read step and a check step.
// Free: walk stops on the target header, a header past it or heap end; idle follows.
// Reset clears heap end and byte total; the header memory needs no clearing pass.
// Result is held in an output register; the next word is accepted while it waits.
// A result that finds the output register still full holds the sequencer and the input.
module first_fit_heap_allocator_core #(
  parameter int HEAP_UNITS = 4096,
  parameter int UNIT_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  ffha_req_if.sink   in_ch,
  ffha_rsp_if.source out_ch
);
  import ffha_pkg::*;

  ctl_t   ctl;
  flags_t flags;

  ffha_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctl   (ctl)
  );

  ffha_datapath #(
    .HEAP_UNITS (HEAP_UNITS),
    .UNIT_BYTES (UNIT_BYTES)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .ctl    (ctl),
    .flags  (flags)
  );

endmodule
`default_nettype wire
